@@ rtl/dmc_pkg.sv @@
// ----------------------------------------------------------------------------
// dmc_pkg
// Shared widths, register indexes and types for the debounced menu cursor.
// ----------------------------------------------------------------------------
package dmc_pkg;

  localparam int unsigned ButtonCount = 3;
  localparam int unsigned IndexWidth  = 8;
  localparam int unsigned CountWidth  = 8;
  localparam int unsigned RowsWidth   = 5;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned CfgDataWidth = 8;

  // Button positions in the level and event vectors
  localparam int unsigned BtnUp     = 0;
  localparam int unsigned BtnDown   = 1;
  localparam int unsigned BtnSelect = 2;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_MENU_LENGTH    = 2'd0,
    CFG_WINDOW_ROWS    = 2'd1,
    CFG_DEBOUNCE_LIMIT = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic pressed;
    logic fired;
  } btn_status_t;

endpackage

@@ rtl/debounced_menu_cursor.sv @@
// ----------------------------------------------------------------------------
// debounced_menu_cursor
// Debounces the up, down and select buttons and moves a scrolling menu cursor.
// ----------------------------------------------------------------------------
// One button sample beat is accepted every cycle while in_stall_o is low. A
// beat is captured in an input register; the three debounce counters and the
// clear, up, then down cursor update then run in one pass and load the result
// register, which offers the result; the cursor update chain (decrement,
// clamp, window scroll compare) runs in that pass.
// Configuration is a plain write port: index 0 menu length, 1 window rows,
// 2 debounce limit; write only while no beat is in flight.
module debounced_menu_cursor (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_we_i,
  input  logic [dmc_pkg::CfgIdxWidth-1:0]    cfg_index_i,
  input  logic [dmc_pkg::CfgDataWidth-1:0]   cfg_data_i,
  // input channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               up_level_i,
  input  logic                               down_level_i,
  input  logic                               select_level_i,
  input  logic                               clear_position_i,
  // output channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [dmc_pkg::IndexWidth-1:0]     selection_o,
  output logic [dmc_pkg::IndexWidth-1:0]     window_offset_o,
  output logic                               up_event_o,
  output logic                               down_event_o,
  output logic                               select_event_o,
  output logic [dmc_pkg::ButtonCount-1:0]    debounced_levels_o
);

  localparam int unsigned IW = dmc_pkg::IndexWidth;

  // Configuration registers
  logic [IW-1:0]                    menu_length_q;
  logic [dmc_pkg::RowsWidth-1:0]    window_rows_q;
  logic [dmc_pkg::CountWidth-1:0]   debounce_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      menu_length_q    <= IW'(4);
      window_rows_q    <= dmc_pkg::RowsWidth'(8);
      debounce_limit_q <= dmc_pkg::CountWidth'(10);
    end else if (cfg_we_i) begin
      unique case (dmc_pkg::cfg_reg_e'(cfg_index_i))
        dmc_pkg::CFG_MENU_LENGTH:    menu_length_q    <= cfg_data_i[IW-1:0];
        dmc_pkg::CFG_WINDOW_ROWS:    window_rows_q    <= cfg_data_i[dmc_pkg::RowsWidth-1:0];
        dmc_pkg::CFG_DEBOUNCE_LIMIT: debounce_limit_q <= cfg_data_i[dmc_pkg::CountWidth-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  logic                             in_valid_q;
  logic [dmc_pkg::ButtonCount-1:0]  level_q;
  logic                             clear_q;
  logic                             out_ready;
  logic                             step;
  logic                             in_accept;

  assign out_ready  = !out_valid_o || !out_stall_i;
  assign step       = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      level_q[dmc_pkg::BtnUp]     <= up_level_i;
      level_q[dmc_pkg::BtnDown]   <= down_level_i;
      level_q[dmc_pkg::BtnSelect] <= select_level_i;
      clear_q                     <= clear_position_i;
    end
  end

  // Debounce counters
  dmc_pkg::btn_status_t btn_status [dmc_pkg::ButtonCount];

  for (genvar b = 0; b < dmc_pkg::ButtonCount; b++) begin : g_btn
    dmc_button u_button (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .step_i   (step),
      .level_i  (level_q[b]),
      .limit_i  (debounce_limit_q),
      .status_o (btn_status[b])
    );
  end

  // Cursor update: clear, then up, then down
  logic [IW-1:0] cursor_q, first_q;
  logic [IW-1:0] cur_clr, first_clr, cur_up, first_up, cur_dn, first_dn;
  logic [IW-1:0] last_idx;
  logic [IW:0]   rows_ext, next_ext, cur_inc;
  logic [IW-1:0] span;
  logic          fire_up, fire_dn;

  assign fire_up = btn_status[dmc_pkg::BtnUp].fired;
  assign fire_dn = btn_status[dmc_pkg::BtnDown].fired;

  always_comb begin
    cur_clr   = clear_q ? '0 : cursor_q;
    first_clr = clear_q ? '0 : first_q;

    cur_up   = cur_clr;
    first_up = first_clr;
    if (fire_up) begin
      if (cur_clr != '0) begin
        cur_up = cur_clr - {{(IW-1){1'b0}}, 1'b1};
      end
      if (first_clr > cur_up) begin
        first_up = cur_up;
      end
    end

    // zero length acts as one entry, zero rows as one row
    last_idx = (menu_length_q == '0) ? '0 : menu_length_q - {{(IW-1){1'b0}}, 1'b1};
    rows_ext = (window_rows_q == '0) ? (IW+1)'(1) : (IW+1)'(window_rows_q);
    next_ext = {1'b0, cur_up} + {{IW{1'b0}}, 1'b1};

    cur_dn   = cur_up;
    first_dn = first_up;
    cur_inc  = '0;
    span     = cur_up - first_up;
    if (fire_dn) begin
      cur_dn  = (next_ext > {1'b0, last_idx}) ? last_idx : next_ext[IW-1:0];
      span    = cur_dn - first_up;
      cur_inc = {1'b0, cur_dn} + {{IW{1'b0}}, 1'b1};
      // scroll only when the cursor sits below the window
      if (cur_dn >= first_up && {1'b0, span} >= rows_ext) begin
        first_dn = (cur_inc >= rows_ext) ? IW'(cur_inc - rows_ext) : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
      first_q  <= '0;
    end else if (step) begin
      cursor_q <= cur_dn;
      first_q  <= first_dn;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_ready) begin
      out_valid_o <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      selection_o     <= cur_dn;
      window_offset_o <= first_dn;
      up_event_o      <= fire_up;
      down_event_o    <= fire_dn;
      select_event_o  <= btn_status[dmc_pkg::BtnSelect].fired;
      for (int b = 0; b < dmc_pkg::ButtonCount; b++) begin
        debounced_levels_o[b] <= btn_status[b].pressed;
      end
    end
  end

  // Assertions
  a_stall_only_when_blocked : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while result register free");

  a_step_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_o)
    else $error("processed beat produced no result");

  a_release_clears_level : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (up_event_o || down_event_o || select_event_o)) |->
      ((!up_event_o || !debounced_levels_o[dmc_pkg::BtnUp]) &&
       (!down_event_o || !debounced_levels_o[dmc_pkg::BtnDown]) &&
       (!select_event_o || !debounced_levels_o[dmc_pkg::BtnSelect])))
    else $error("release event with button still pressed");

endmodule

@@ rtl/dmc_button.sv @@
// ----------------------------------------------------------------------------
// dmc_button
// Integrating debounce counter for one active-low button line.
// ----------------------------------------------------------------------------
module dmc_button (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             step_i,
  input  logic                             level_i,
  input  logic [dmc_pkg::CountWidth-1:0]   limit_i,
  output dmc_pkg::btn_status_t             status_o
);

  logic [dmc_pkg::CountWidth-1:0] count_q, count_d;
  logic                           pressed_q, pressed_d;

  always_comb begin
    count_d   = count_q;
    pressed_d = pressed_q;
    if (!level_i) begin
      // line held low: integrate up, saturate at the limit
      if (count_q < limit_i) begin
        count_d = count_q + {{(dmc_pkg::CountWidth-1){1'b0}}, 1'b1};
        if (count_d == limit_i) begin
          pressed_d = 1'b1;
        end
      end
    end else if (count_q != '0) begin
      count_d = count_q - {{(dmc_pkg::CountWidth-1){1'b0}}, 1'b1};
      if (count_d == '0) begin
        pressed_d = 1'b0;
      end
    end
  end

  assign status_o.pressed = pressed_d;
  assign status_o.fired   = pressed_q & ~pressed_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      pressed_q <= 1'b0;
    end else if (step_i) begin
      count_q   <= count_d;
      pressed_q <= pressed_d;
    end
  end

endmodule

@@ sim/tb_debounced_menu_cursor.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_debounced_menu_cursor
// Self-checking bench for the button debouncer and scrolling menu cursor.
// ----------------------------------------------------------------------------
// A short table of hand-picked beats runs first; a few rows carry their result
// typed in, the rest are checked against a behavioural cursor model kept in
// this bench. Several random phases follow, each with its own register
// settings and idling pattern: bouncy button presses, a steady down sweep, and
// all buttons held while the counters climb towards a high limit.
module tb_debounced_menu_cursor;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned IW = dmc_pkg::IndexWidth;

  typedef struct packed {
    logic [IW-1:0]                   selection;
    logic [IW-1:0]                   window_offset;
    logic                            up_event;
    logic                            down_event;
    logic                            select_event;
    logic [dmc_pkg::ButtonCount-1:0] levels;
  } cursor_out_t;

  // lines are {clear, select, down, up}; buttons are active low
  typedef struct packed {
    logic [3:0]  lines;
    logic        typed;
    cursor_out_t res;
  } stim_row_t;

  typedef enum logic [1:0] {
    GEN_BOUNCY,
    GEN_SWEEP,
    GEN_HOLD
  } gen_mode_e;

  typedef struct packed {
    logic [7:0]  menu;
    logic [7:0]  rows;
    logic [7:0]  limit;
    gen_mode_e   mode;
    logic [6:0]  idle_pct;
    logic [6:0]  stall_pct;
    logic [15:0] beats;
  } phase_t;

  // config for the table: three entries, one visible row, limit of one tick
  stim_row_t button_table [15] = '{
    '{4'b0111, 1'b1, '{8'd0, 8'd0, 1'b0, 1'b0, 1'b0, 3'b000}},
    '{4'b0110, 1'b1, '{8'd0, 8'd0, 1'b0, 1'b0, 1'b0, 3'b001}},
    '{4'b0111, 1'b1, '{8'd0, 8'd0, 1'b1, 1'b0, 1'b0, 3'b000}},
    '{4'b0101, 1'b0, cursor_out_t'(0)},
    '{4'b0111, 1'b0, cursor_out_t'(0)},
    '{4'b0101, 1'b0, cursor_out_t'(0)},
    '{4'b0111, 1'b0, cursor_out_t'(0)},
    '{4'b0101, 1'b0, cursor_out_t'(0)},
    '{4'b0111, 1'b0, cursor_out_t'(0)},
    '{4'b0011, 1'b0, cursor_out_t'(0)},
    '{4'b0111, 1'b0, cursor_out_t'(0)},
    '{4'b0000, 1'b1, '{8'd2, 8'd2, 1'b0, 1'b0, 1'b0, 3'b111}},
    '{4'b0111, 1'b0, cursor_out_t'(0)},
    '{4'b1000, 1'b1, '{8'd0, 8'd0, 1'b0, 1'b0, 1'b0, 3'b111}},
    '{4'b1111, 1'b0, cursor_out_t'(0)}
  };

  phase_t phases [9] = '{
    '{8'd4,   8'd8,  8'd10,  GEN_BOUNCY, 7'd0,  7'd0,  16'd150},
    '{8'd100, 8'd16, 8'd1,   GEN_SWEEP,  7'd75, 7'd0,  16'd260},
    '{8'd10,  8'd3,  8'd2,   GEN_BOUNCY, 7'd0,  7'd75, 16'd200},
    '{8'd0,   8'd0,  8'd3,   GEN_BOUNCY, 7'd29, 7'd29, 16'd120},
    '{8'd255, 8'd31, 8'd255, GEN_HOLD,   7'd0,  7'd0,  16'd120},
    '{8'd255, 8'd1,  8'd4,   GEN_BOUNCY, 7'd75, 7'd0,  16'd150},
    '{8'd7,   8'd2,  8'd0,   GEN_BOUNCY, 7'd0,  7'd75, 16'd80},
    '{8'd1,   8'd1,  8'd1,   GEN_BOUNCY, 7'd29, 7'd29, 16'd120},
    '{8'd255, 8'd16, 8'd6,   GEN_BOUNCY, 7'd0,  7'd0,  16'd100}
  };

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             cfg_we_i = 1'b0;
  logic [dmc_pkg::CfgIdxWidth-1:0]  cfg_index_i = dmc_pkg::CFG_MENU_LENGTH;
  logic [dmc_pkg::CfgDataWidth-1:0] cfg_data_i = '0;
  logic                             in_valid_i = 1'b0;
  logic                             in_stall_o;
  logic                             up_level_i = 1'b1;
  logic                             down_level_i = 1'b1;
  logic                             select_level_i = 1'b1;
  logic                             clear_position_i = 1'b0;
  logic                             out_valid_o;
  logic                             out_stall_i = 1'b0;
  logic [IW-1:0]                    selection_o;
  logic [IW-1:0]                    window_offset_o;
  logic                             up_event_o;
  logic                             down_event_o;
  logic                             select_event_o;
  logic [dmc_pkg::ButtonCount-1:0]  debounced_levels_o;

  debounced_menu_cursor dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .up_level_i         (up_level_i),
    .down_level_i       (down_level_i),
    .select_level_i     (select_level_i),
    .clear_position_i   (clear_position_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .selection_o        (selection_o),
    .window_offset_o    (window_offset_o),
    .up_event_o         (up_event_o),
    .down_event_o       (down_event_o),
    .select_event_o     (select_event_o),
    .debounced_levels_o (debounced_levels_o)
  );

  // cursor model state and its copy of the registers
  logic [dmc_pkg::CountWidth-1:0]  press_cnt [dmc_pkg::ButtonCount];
  logic [dmc_pkg::ButtonCount-1:0] held_flag;
  logic [dmc_pkg::ButtonCount-1:0] held_last;
  logic [IW-1:0]                   cursor;
  logic [IW-1:0]                   top_row;
  logic [7:0]                      menu_len;
  logic [dmc_pkg::RowsWidth-1:0]   visible_rows;
  logic [dmc_pkg::CountWidth-1:0]  press_limit;

  cursor_out_t expected_cursor [$];
  int          errors = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  logic        row_typed = 1'b0;
  cursor_out_t row_expect = '0;

  // random button generator state
  logic [2:0]  line_state = 3'b111;
  int unsigned run_left [3] = '{0, 0, 0};
  logic        sweep_down = 1'b1;

  initial forever #4 clk_i = ~clk_i;

  always @(negedge clk_i) out_stall_i <= ($urandom_range(0, 99) < stall_pct);

  function automatic cursor_out_t predict_tick(input logic [3:0] lines);
    cursor_out_t r;
    logic [2:0]  fired;
    int          last_idx;
    int          rows;
    int          cur;
    if (lines[3]) begin
      cursor  = '0;
      top_row = '0;
    end
    for (int b = 0; b < dmc_pkg::ButtonCount; b++) begin
      if (!lines[b]) begin
        if (press_cnt[b] < press_limit) begin
          press_cnt[b]++;
          if (press_cnt[b] == press_limit) held_flag[b] = 1'b1;
        end
      end else if (press_cnt[b] > 0) begin
        press_cnt[b]--;
        if (press_cnt[b] == 0) held_flag[b] = 1'b0;
      end
      fired[b]     = held_last[b] && !held_flag[b];
      held_last[b] = held_flag[b];
      if (fired[b] && b == dmc_pkg::BtnUp) begin
        if (cursor > 0) cursor--;
        if (top_row > cursor) top_row = cursor;
      end else if (fired[b] && b == dmc_pkg::BtnDown) begin
        last_idx = (menu_len == 0) ? 0 : int'(menu_len) - 1;
        rows     = (visible_rows == 0) ? 1 : int'(visible_rows);
        cur      = int'(cursor) + 1;
        if (cur > last_idx) cur = last_idx;
        cursor = IW'(cur);
        // scroll only when the cursor has dropped below the window
        if (cursor >= top_row && int'(cursor) - int'(top_row) >= rows) begin
          top_row = (int'(cursor) + 1 >= rows) ? IW'(int'(cursor) + 1 - rows) : '0;
        end
      end
    end
    r.selection     = cursor;
    r.window_offset = top_row;
    r.up_event      = fired[dmc_pkg::BtnUp];
    r.down_event    = fired[dmc_pkg::BtnDown];
    r.select_event  = fired[dmc_pkg::BtnSelect];
    r.levels        = held_flag;
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    cursor_out_t want;
    logic        in_beat;
    logic        out_beat;
    in_beat  = in_valid_i && !in_stall_o;
    out_beat = out_valid_o && !out_stall_i;
    if (!rst_ni) begin
      for (int b = 0; b < dmc_pkg::ButtonCount; b++) press_cnt[b] = '0;
      held_flag    = '0;
      held_last    = '0;
      cursor       = '0;
      top_row      = '0;
      menu_len     = 8'd4;
      visible_rows = 5'd8;
      press_limit  = 8'd10;
    end else begin
      if (out_beat) begin
        if (expected_cursor.size() == 0) begin
          $error("result beat with no expectation waiting");
          errors++;
        end else begin
          want = expected_cursor.pop_front();
          check_field("selection", 32'(want.selection), 32'(selection_o));
          check_field("window_offset", 32'(want.window_offset), 32'(window_offset_o));
          check_field("up_event", 32'(want.up_event), 32'(up_event_o));
          check_field("down_event", 32'(want.down_event), 32'(down_event_o));
          check_field("select_event", 32'(want.select_event), 32'(select_event_o));
          check_field("debounced_levels", 32'(want.levels), 32'(debounced_levels_o));
        end
      end
      if (cfg_we_i) begin
        case (dmc_pkg::cfg_reg_e'(cfg_index_i))
          dmc_pkg::CFG_MENU_LENGTH:    menu_len     = cfg_data_i;
          dmc_pkg::CFG_WINDOW_ROWS:    visible_rows = cfg_data_i[dmc_pkg::RowsWidth-1:0];
          dmc_pkg::CFG_DEBOUNCE_LIMIT: press_limit  = cfg_data_i;
          default: ;
        endcase
      end
      if (in_beat) begin
        want = predict_tick({clear_position_i, select_level_i, down_level_i, up_level_i});
        if (row_typed) want = row_expect;
        expected_cursor.push_back(want);
      end
    end
    quiet_cycles <= (in_beat || out_beat) ? 0 : quiet_cycles + 1;
  end

  always @(posedge clk_i) begin
    if (quiet_cycles >= WatchdogLimit) begin
      $display("debounced_menu_cursor test failed");
      $finish;
    end
  end

  // entered just after a falling edge, returns just after one
  task automatic drive_beat(input logic [3:0] lines, input logic typed,
                            input cursor_out_t res);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    up_level_i       <= lines[0];
    down_level_i     <= lines[1];
    select_level_i   <= lines[2];
    clear_position_i <= lines[3];
    row_typed        <= typed;
    row_expect       <= res;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // drain every result before touching the registers
  task automatic write_regs(input logic [7:0] menu, input logic [7:0] rows,
                            input logic [7:0] limit);
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (expected_cursor.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= dmc_pkg::CFG_MENU_LENGTH;
    cfg_data_i  <= menu;
    @(negedge clk_i);
    cfg_index_i <= dmc_pkg::CFG_WINDOW_ROWS;
    cfg_data_i  <= rows;
    @(negedge clk_i);
    cfg_index_i <= dmc_pkg::CFG_DEBOUNCE_LIMIT;
    cfg_data_i  <= limit;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [3:0] next_lines(input gen_mode_e mode, input int unsigned limit);
    logic [3:0]  lines;
    int unsigned lo;
    lo = (limit == 0) ? 1 : limit;
    case (mode)
      GEN_SWEEP: begin
        // down toggles every beat: one release every other beat
        sweep_down = ~sweep_down;
        lines = {1'b0, 1'b1, sweep_down, 1'b1};
      end
      GEN_HOLD: lines = {($urandom_range(0, 19) == 0), 3'b000};
      default: begin
        for (int b = 0; b < 3; b++) begin
          if (run_left[b] == 0) begin
            line_state[b] = ~line_state[b];
            run_left[b] = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2)
                                                      : $urandom_range(lo, lo + 4);
          end
          run_left[b]--;
          // short glitch on top of the steady level
          lines[b] = line_state[b] ^ ($urandom_range(0, 19) == 0);
        end
        lines[3] = ($urandom_range(0, 49) == 0);
      end
    endcase
    return lines;
  endfunction

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    write_regs(8'd3, 8'd1, 8'd1);
    foreach (button_table[i]) begin
      drive_beat(button_table[i].lines, button_table[i].typed, button_table[i].res);
    end

    foreach (phases[p]) begin
      write_regs(phases[p].menu, phases[p].rows, phases[p].limit);
      send_idle_pct = 32'(phases[p].idle_pct);
      stall_pct     = 32'(phases[p].stall_pct);
      for (int n = 0; n < phases[p].beats; n++) begin
        drive_beat(next_lines(phases[p].mode, 32'(phases[p].limit)), 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    stall_pct = 0;
    while (expected_cursor.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    if (errors == 0) begin
      $display("debounced_menu_cursor test passed");
    end else begin
      $display("debounced_menu_cursor test failed");
    end
    $finish;
  end

endmodule
